// ===== src/scfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync CRC frame parser package
// Shared constants, codes, record types and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package scfp_pkg;

  localparam int VELOCITY_FRAME_BYTES = 12;
  localparam int CONTROL_FRAME_BYTES  = 16;
  localparam int PAYLOAD_MAX_BYTES    = 8;
  localparam int COUNTER_BITS         = 32;

  localparam int HELD_BITS = $clog2(CONTROL_FRAME_BYTES + 1);
  localparam int IDX_BITS  = $clog2(CONTROL_FRAME_BYTES);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  localparam logic [7:0] SYNC_FIRST_RESET       = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RESET      = 8'h55;
  localparam logic [7:0] VELOCITY_VERSION_RESET = 8'h01;
  localparam logic [7:0] CONTROL_VERSION_RESET  = 8'h02;

  // Byte positions inside a frame.
  localparam int VER_POS         = 2;
  localparam int VEL_SEQ_POS     = 3;
  localparam int VEL_X_POS       = 4;
  localparam int VEL_Y_POS       = 6;
  localparam int YAW_POS         = 8;
  localparam int CTL_CODE_POS    = 3;
  localparam int CTL_SEQ_POS     = 4;
  localparam int CTL_COUNT_POS   = 5;
  localparam int CTL_PAYLOAD_POS = 6;

  // Frame bytes carried from the parser to the decoder.
  localparam int BODY_FIRST = 3;
  localparam int BODY_BYTES = CTL_PAYLOAD_POS + PAYLOAD_MAX_BYTES - BODY_FIRST;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_INCOMPLETE  = 3'd0,
    ST_VALID       = 3'd1,
    ST_BAD_HEADER  = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_BAD_CRC     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_SYNC_FIRST       = 2'd0,
    CFG_SYNC_SECOND      = 2'd1,
    CFG_VELOCITY_VERSION = 2'd2,
    CFG_CONTROL_VERSION  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] velocity_version;
    logic [7:0] control_version;
  } cfg_t;

  typedef struct packed {
    status_t                    status;
    logic                       kind;
    logic [BODY_BYTES-1:0][7:0] body;
  } rec_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== src/scfp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser front end
// Hunts for the sync header, stores frame bytes, runs the CRC and
// classifies every accepted word.
// ----------------------------------------------------------------------------
module scfp_front (
  input  logic            clk,
  input  logic            rst,
  input  scfp_pkg::cfg_t  cfg,
  input  logic            accept,
  input  logic [7:0]      byte_in,
  output scfp_pkg::rec_t  rec
);
  import scfp_pkg::*;

  logic [HELD_BITS-1:0] bytes_held;
  logic [HELD_BITS-1:0] bytes_held_next;
  logic [15:0]          running_crc;
  logic [15:0]          running_crc_next;
  logic [7:0]           frame_store [CONTROL_FRAME_BYTES];

  logic [IDX_BITS-1:0]  idx;
  logic [IDX_BITS-1:0]  wr_idx;
  logic [HELD_BITS-1:0] held_inc;
  logic [HELD_BITS-1:0] size;
  logic [15:0]          crc_step;
  logic [15:0]          crc_first;
  logic [15:0]          crc_new;
  logic [7:0]           trailer_lo;
  logic [7:0]           trailer_hi;
  logic                 keep_first;
  logic                 is_ver;
  logic                 ctl;
  logic                 store_wr;
  logic                 store0_wr;
  logic                 resync;
  status_t              status;

  always_comb begin
    idx        = bytes_held[IDX_BITS-1:0];
    held_inc   = bytes_held + 1'b1;
    crc_step   = crc_byte(running_crc, byte_in);
    crc_first  = crc_byte(CRC_INIT, cfg.sync_first);
    keep_first = (byte_in == cfg.sync_first);
    is_ver     = (idx == IDX_BITS'(VER_POS));
    ctl        = ((is_ver ? byte_in : frame_store[VER_POS]) == cfg.control_version);
    size       = ctl ? HELD_BITS'(CONTROL_FRAME_BYTES) : HELD_BITS'(VELOCITY_FRAME_BYTES);
    crc_new    = ({1'b0, idx} < size - HELD_BITS'(2)) ? crc_step : running_crc;
    trailer_lo = ctl ? frame_store[CONTROL_FRAME_BYTES-2] : frame_store[VELOCITY_FRAME_BYTES-2];
    if ({1'b0, idx} == size - HELD_BITS'(1)) begin
      trailer_hi = byte_in;
    end else begin
      trailer_hi = ctl ? frame_store[CONTROL_FRAME_BYTES-1]
                       : frame_store[VELOCITY_FRAME_BYTES-1];
    end

    bytes_held_next  = bytes_held;
    running_crc_next = running_crc;
    status           = ST_INCOMPLETE;
    store_wr         = 1'b0;
    store0_wr        = 1'b0;
    wr_idx           = idx;
    resync           = 1'b0;

    priority if (bytes_held == '0) begin
      if (keep_first) begin
        store0_wr        = 1'b1;
        bytes_held_next  = HELD_BITS'(1);
        running_crc_next = crc_first;
      end
    end else if (bytes_held == HELD_BITS'(1)) begin
      if (byte_in == cfg.sync_second) begin
        store_wr         = 1'b1;
        bytes_held_next  = HELD_BITS'(2);
        running_crc_next = crc_step;
      end else if (!keep_first) begin
        bytes_held_next  = '0;
        running_crc_next = CRC_INIT;
        status           = ST_BAD_HEADER;
      end
    end else begin
      store_wr = 1'b1;
      if (is_ver && byte_in != cfg.velocity_version && byte_in != cfg.control_version) begin
        resync = 1'b1;
        status = ST_BAD_VERSION;
      end else begin
        bytes_held_next  = held_inc;
        running_crc_next = crc_new;
        if (held_inc >= size) begin
          if ({trailer_hi, trailer_lo} != crc_new) begin
            resync = 1'b1;
            status = ST_BAD_CRC;
          end else if (ctl && frame_store[CTL_COUNT_POS] > 8'(PAYLOAD_MAX_BYTES)) begin
            resync = 1'b1;
            status = ST_BAD_HEADER;
          end else begin
            status           = ST_VALID;
            bytes_held_next  = '0;
            running_crc_next = CRC_INIT;
          end
        end
      end
    end

    // A trailing first sync byte opens the next hunt.
    if (resync) begin
      store0_wr        = keep_first;
      bytes_held_next  = keep_first ? HELD_BITS'(1) : '0;
      running_crc_next = keep_first ? crc_first : CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_held  <= '0;
      running_crc <= CRC_INIT;
    end else if (accept) begin
      bytes_held  <= bytes_held_next;
      running_crc <= running_crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < CONTROL_FRAME_BYTES; i++) begin
        if (store_wr && wr_idx == IDX_BITS'(i)) begin
          frame_store[i] <= byte_in;
        end
      end
      if (store0_wr) begin
        frame_store[0] <= cfg.sync_first;
      end
    end
  end

  always_comb begin
    rec.status = status;
    rec.kind   = ctl;
    for (int k = 0; k < BODY_BYTES; k++) begin
      rec.body[k] = frame_store[BODY_FIRST + k];
    end
  end

endmodule

// ===== src/scfp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parser record queue
// Short first-in first-out buffer between the parser and the decoder.
// ----------------------------------------------------------------------------
module scfp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  scfp_pkg::rec_t  push_rec,
  output logic            full,
  input  logic            pop,
  output scfp_pkg::rec_t  pop_rec,
  output logic            empty
);
  import scfp_pkg::*;

  rec_t                   entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCOUNT_BITS-1:0] count;
  logic [QPTR_BITS-1:0]   wr_ptr_next;
  logic [QPTR_BITS-1:0]   rd_ptr_next;

  assign wr_ptr_next = (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next = (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
  assign full        = (count == QCOUNT_BITS'(QUEUE_DEPTH));
  assign empty       = (count == '0);
  assign pop_rec     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

// ===== src/scfp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame decoder back end
// Decodes good frames, keeps the event counters and holds the result word.
// ----------------------------------------------------------------------------
module scfp_back (
  input  logic               clk,
  input  logic               rst,
  input  scfp_pkg::rec_t     rec,
  input  logic               rec_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic               frame_kind,
  output logic [7:0]         sequence_res,
  output logic signed [15:0] velocity_x,
  output logic signed [15:0] velocity_y,
  output logic signed [15:0] yaw_rate,
  output logic [7:0]         control_code,
  output logic [3:0]         payload_count,
  output logic [63:0]        payload_bytes,
  output logic [31:0]        good_frames,
  output logic [31:0]        crc_failures,
  output logic [31:0]        resyncs
);
  import scfp_pkg::*;

  logic [COUNTER_BITS-1:0] valid_counter;
  logic [COUNTER_BITS-1:0] crc_error_counter;
  logic [COUNTER_BITS-1:0] resync_counter;
  logic                    is_valid;
  logic                    is_vel;
  logic                    is_ctl;
  logic                    is_resync;

  assign pop       = rec_valid && (!out_valid || out_ready);
  assign is_valid  = (rec.status == ST_VALID);
  assign is_vel    = is_valid && !rec.kind;
  assign is_ctl    = is_valid && rec.kind;
  assign is_resync = (rec.status == ST_BAD_HEADER) || (rec.status == ST_BAD_VERSION)
                     || (rec.status == ST_BAD_CRC);

  assign good_frames  = 32'(valid_counter);
  assign crc_failures = 32'(crc_error_counter);
  assign resyncs      = 32'(resync_counter);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      valid_counter     <= '0;
      crc_error_counter <= '0;
      resync_counter    <= '0;
    end else if (pop) begin
      out_valid <= 1'b1;
      if (is_valid) begin
        valid_counter <= valid_counter + 1'b1;
      end
      if (rec.status == ST_BAD_CRC) begin
        crc_error_counter <= crc_error_counter + 1'b1;
      end
      if (is_resync) begin
        resync_counter <= resync_counter + 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status     <= rec.status;
      frame_kind <= is_ctl;
      if (is_vel) begin
        sequence_res <= rec.body[VEL_SEQ_POS-BODY_FIRST];
      end else if (is_ctl) begin
        sequence_res <= rec.body[CTL_SEQ_POS-BODY_FIRST];
      end else begin
        sequence_res <= '0;
      end
      velocity_x    <= is_vel ? {rec.body[VEL_X_POS-BODY_FIRST+1],
                                 rec.body[VEL_X_POS-BODY_FIRST]} : '0;
      velocity_y    <= is_vel ? {rec.body[VEL_Y_POS-BODY_FIRST+1],
                                 rec.body[VEL_Y_POS-BODY_FIRST]} : '0;
      yaw_rate      <= is_vel ? {rec.body[YAW_POS-BODY_FIRST+1],
                                 rec.body[YAW_POS-BODY_FIRST]} : '0;
      control_code  <= is_ctl ? rec.body[CTL_CODE_POS-BODY_FIRST] : '0;
      payload_count <= is_ctl ? rec.body[CTL_COUNT_POS-BODY_FIRST][3:0] : '0;
      payload_bytes <= is_ctl ? 64'(rec.body[CTL_PAYLOAD_POS-BODY_FIRST +: PAYLOAD_MAX_BYTES])
                              : '0;
    end
  end

  a_good_count: assert property (@(posedge clk) disable iff (rst)
    pop && is_valid |=> valid_counter == COUNTER_BITS'($past(valid_counter) + 1'b1))
    else $error("good frame count did not advance on a valid frame");

  a_crc_count: assert property (@(posedge clk) disable iff (rst)
    pop && rec.status == ST_BAD_CRC |=>
      crc_error_counter == COUNTER_BITS'($past(crc_error_counter) + 1'b1) &&
      resync_counter == COUNTER_BITS'($past(resync_counter) + 1'b1))
    else $error("CRC failure not counted as both a failure and a resync");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_VALID |->
      !frame_kind && sequence_res == '0 && payload_bytes == '0 && velocity_x == '0)
    else $error("decoded fields not zero on a word that is not a valid frame");

endmodule

// ===== src/sync_crc_frame_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync CRC frame parser
// Byte-serial parser for sync-headed velocity and control frames with a
// CRC-16 check, built as a parser front end, a record queue and a decoder.
// ----------------------------------------------------------------------------
// An accepted word is written into the record queue, and its result is
// registered on the outputs when the decoder pops it from the queue.
// Throughput: one word per cycle while the queue has room; a combinational
// parser step folds the byte into the CRC and checks header, version, trailer.
// Reset (rst, synchronous): clears parser state, queue, counters and output
// valid, and restores the register defaults; the frame store is not cleared.
// ----------------------------------------------------------------------------
module sync_crc_frame_parser_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         byte_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic               frame_kind,
  output logic [7:0]         sequence_res,
  output logic signed [15:0] velocity_x,
  output logic signed [15:0] velocity_y,
  output logic signed [15:0] yaw_rate,
  output logic [7:0]         control_code,
  output logic [3:0]         payload_count,
  output logic [63:0]        payload_bytes,
  output logic [31:0]        good_frames,
  output logic [31:0]        crc_failures,
  output logic [31:0]        resyncs
);
  import scfp_pkg::*;

  cfg_t     cfg;
  rec_t     front_rec;
  rec_t     back_rec;
  logic     accept;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  cfg_idx_t cfg_sel;

  assign cfg_sel  = cfg_idx_t'(cfg_index);
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first       <= SYNC_FIRST_RESET;
      cfg.sync_second      <= SYNC_SECOND_RESET;
      cfg.velocity_version <= VELOCITY_VERSION_RESET;
      cfg.control_version  <= CONTROL_VERSION_RESET;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        CFG_SYNC_FIRST:       cfg.sync_first       <= cfg_data;
        CFG_SYNC_SECOND:      cfg.sync_second      <= cfg_data;
        CFG_VELOCITY_VERSION: cfg.velocity_version <= cfg_data;
        CFG_CONTROL_VERSION:  cfg.control_version  <= cfg_data;
      endcase
    end
  end

  scfp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .byte_in (byte_in),
    .rec     (front_rec)
  );

  scfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_rec (front_rec),
    .full     (q_full),
    .pop      (q_pop),
    .pop_rec  (back_rec),
    .empty    (q_empty)
  );

  scfp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .rec           (back_rec),
    .rec_valid     (!q_empty),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .frame_kind    (frame_kind),
    .sequence_res  (sequence_res),
    .velocity_x    (velocity_x),
    .velocity_y    (velocity_y),
    .yaw_rate      (yaw_rate),
    .control_code  (control_code),
    .payload_count (payload_count),
    .payload_bytes (payload_bytes),
    .good_frames   (good_frames),
    .crc_failures  (crc_failures),
    .resyncs       (resyncs)
  );

endmodule

// ===== sim/tb_sync_crc_frame_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync CRC frame parser testbench
// Streams good and damaged velocity and control frames, line noise and
// truncated frames through the parser under several register settings.
// Both channels stall at random, and a long output stall fills the block.
// A cycle-free model of the parser predicts every result word, and each
// word is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_sync_crc_frame_parser_unit;
  import scfp_pkg::*;

  localparam int WATCHDOG_LIMIT   = 1000;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int MAX_REPORTS      = 10;

  typedef enum int {
    DEF_NONE,
    DEF_CRC,
    DEF_CRC_TAIL,
    DEF_COUNT,
    DEF_VERSION,
    DEF_VERSION_SYNC,
    DEF_SECOND,
    DEF_REPEAT,
    DEF_TRUNCATE
  } defect_t;

  typedef enum int {
    FILL_RANDOM,
    FILL_LOW,
    FILL_HIGH,
    FILL_EDGE
  } fill_t;

  typedef struct packed {
    status_t            status;
    logic               kind;
    logic [7:0]         seq;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] yaw;
    logic [7:0]         code;
    logic [3:0]         count;
    logic [63:0]        payload;
    logic [31:0]        good;
    logic [31:0]        crc_fail;
    logic [31:0]        resync;
  } frame_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = 2'd0;
  logic [7:0]         cfg_data = 8'h00;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         byte_in = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         status;
  logic               frame_kind;
  logic [7:0]         sequence_res;
  logic signed [15:0] velocity_x;
  logic signed [15:0] velocity_y;
  logic signed [15:0] yaw_rate;
  logic [7:0]         control_code;
  logic [3:0]         payload_count;
  logic [63:0]        payload_bytes;
  logic [31:0]        good_frames;
  logic [31:0]        crc_failures;
  logic [31:0]        resyncs;

  // Parser model state and its copy of the registers.
  logic [7:0]  cur_sync_first;
  logic [7:0]  cur_sync_second;
  logic [7:0]  cur_vel_ver;
  logic [7:0]  cur_ctl_ver;
  logic [7:0]  stored_bytes [16];
  logic [4:0]  bytes_in_frame;
  logic [15:0] crc_acc;
  logic [31:0] pred_good;
  logic [31:0] pred_crc_fail;
  logic [31:0] pred_resync;

  frame_result_t pending_results [$];

  int  errors = 0;
  int  words_checked = 0;
  int  bytes_sent = 0;
  int  frames_sent = 0;
  int  settings_used = 0;
  int  quiet_cycles = 0;
  bit  idle_on = 1'b1;
  bit  hold_request = 1'b0;
  int  hold_left = 0;
  int  ready_gap = 0;

  sync_crc_frame_parser_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_in      (byte_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .frame_kind   (frame_kind),
    .sequence_res (sequence_res),
    .velocity_x   (velocity_x),
    .velocity_y   (velocity_y),
    .yaw_rate     (yaw_rate),
    .control_code (control_code),
    .payload_count(payload_count),
    .payload_bytes(payload_bytes),
    .good_frames  (good_frames),
    .crc_failures (crc_failures),
    .resyncs      (resyncs)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] ccitt_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void restart_hunt();
    logic [3:0] last;
    last = 4'(bytes_in_frame - 5'd1);
    if (bytes_in_frame != 5'd0 && stored_bytes[last] == cur_sync_first) begin
      stored_bytes[0] = cur_sync_first;
      bytes_in_frame = 5'd1;
      crc_acc = ccitt_update(CRC_INIT, cur_sync_first);
    end else begin
      bytes_in_frame = 5'd0;
      crc_acc = CRC_INIT;
    end
    pred_resync = pred_resync + 32'd1;
  endfunction

  function automatic frame_result_t parse_byte(input logic [7:0] b);
    frame_result_t r;
    logic [3:0]    slot;
    logic          ctl;
    int            size;
    logic [15:0]   trailer;
    r = '0;
    if (bytes_in_frame == 5'd0) begin
      if (b == cur_sync_first) begin
        stored_bytes[0] = b;
        bytes_in_frame = 5'd1;
        crc_acc = ccitt_update(CRC_INIT, b);
      end
    end else if (bytes_in_frame == 5'd1) begin
      if (b == cur_sync_second) begin
        stored_bytes[1] = b;
        bytes_in_frame = 5'd2;
        crc_acc = ccitt_update(crc_acc, b);
      end else if (b != cur_sync_first) begin
        bytes_in_frame = 5'd0;
        crc_acc = CRC_INIT;
        pred_resync = pred_resync + 32'd1;
        r.status = ST_BAD_HEADER;
      end
    end else begin
      slot = bytes_in_frame[3:0];
      stored_bytes[slot] = b;
      bytes_in_frame = bytes_in_frame + 5'd1;
      if (bytes_in_frame == 5'd3 && b != cur_vel_ver && b != cur_ctl_ver) begin
        restart_hunt();
        r.status = ST_BAD_VERSION;
      end else begin
        ctl = (stored_bytes[VER_POS] == cur_ctl_ver);
        size = ctl ? CONTROL_FRAME_BYTES : VELOCITY_FRAME_BYTES;
        if (slot < size - 2) crc_acc = ccitt_update(crc_acc, b);
        if (bytes_in_frame >= size) begin
          trailer = {stored_bytes[size-1], stored_bytes[size-2]};
          if (trailer != crc_acc) begin
            pred_crc_fail = pred_crc_fail + 32'd1;
            restart_hunt();
            r.status = ST_BAD_CRC;
          end else if (ctl && stored_bytes[CTL_COUNT_POS] > PAYLOAD_MAX_BYTES) begin
            restart_hunt();
            r.status = ST_BAD_HEADER;
          end else begin
            r.status = ST_VALID;
            if (ctl) begin
              r.kind = 1'b1;
              r.seq = stored_bytes[CTL_SEQ_POS];
              r.code = stored_bytes[CTL_CODE_POS];
              r.count = stored_bytes[CTL_COUNT_POS][3:0];
              for (int i = 0; i < PAYLOAD_MAX_BYTES; i++) begin
                r.payload[8*i +: 8] = stored_bytes[CTL_PAYLOAD_POS + i];
              end
            end else begin
              r.seq = stored_bytes[VEL_SEQ_POS];
              r.vx = {stored_bytes[VEL_X_POS+1], stored_bytes[VEL_X_POS]};
              r.vy = {stored_bytes[VEL_Y_POS+1], stored_bytes[VEL_Y_POS]};
              r.yaw = {stored_bytes[YAW_POS+1], stored_bytes[YAW_POS]};
            end
            pred_good = pred_good + 32'd1;
            bytes_in_frame = 5'd0;
            crc_acc = CRC_INIT;
          end
        end
      end
    end
    r.good = pred_good;
    r.crc_fail = pred_crc_fail;
    r.resync = pred_resync;
    return r;
  endfunction

  function automatic string describe(input frame_result_t r);
    return $sformatf({"st=%0d kind=%0d seq=%02h vx=%0d vy=%0d yaw=%0d code=%02h n=%0d",
                      " pl=%016h %0d/%0d/%0d"},
                     r.status, r.kind, r.seq, $signed(r.vx), $signed(r.vy), $signed(r.yaw),
                     r.code, r.count, r.payload, r.good, r.crc_fail, r.resync);
  endfunction

  // Predicts each accepted input word and checks each accepted result word.
  always @(posedge clk) begin : monitor
    frame_result_t got;
    frame_result_t want;
    string         bad;
    if (!rst) begin
      if (in_valid && in_ready) pending_results.push_back(parse_byte(byte_in));
      if (out_valid && out_ready) begin
        got.status = status_t'(status);
        got.kind = frame_kind;
        got.seq = sequence_res;
        got.vx = velocity_x;
        got.vy = velocity_y;
        got.yaw = yaw_rate;
        got.code = control_code;
        got.count = payload_count;
        got.payload = payload_bytes;
        got.good = good_frames;
        got.crc_fail = crc_failures;
        got.resync = resyncs;
        words_checked++;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("unexpected result word %0d: %s", words_checked, describe(got));
          end
        end else begin
          want = pending_results.pop_front();
          bad = "";
          if (got.status !== want.status) bad = {bad, " status"};
          if (got.kind !== want.kind) bad = {bad, " frame_kind"};
          if (got.seq !== want.seq) bad = {bad, " sequence_res"};
          if (got.vx !== want.vx) bad = {bad, " velocity_x"};
          if (got.vy !== want.vy) bad = {bad, " velocity_y"};
          if (got.yaw !== want.yaw) bad = {bad, " yaw_rate"};
          if (got.code !== want.code) bad = {bad, " control_code"};
          if (got.count !== want.count) bad = {bad, " payload_count"};
          if (got.payload !== want.payload) bad = {bad, " payload_bytes"};
          if (got.good !== want.good) bad = {bad, " good_frames"};
          if (got.crc_fail !== want.crc_fail) bad = {bad, " crc_failures"};
          if (got.resync !== want.resync) bad = {bad, " resyncs"};
          if (bad.len() != 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("mismatch on result word %0d:%s", words_checked, bad);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no word moved for %0d cycles", quiet_cycles);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  // Result side: random stall bursts, plus one long hold on request.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = LONG_HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      ready_gap = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic reset_block();
    cur_sync_first = SYNC_FIRST_RESET;
    cur_sync_second = SYNC_SECOND_RESET;
    cur_vel_ver = VELOCITY_VERSION_RESET;
    cur_ctl_ver = CONTROL_VERSION_RESET;
    foreach (stored_bytes[i]) stored_bytes[i] = 8'h00;
    bytes_in_frame = 5'd0;
    crc_acc = CRC_INIT;
    pred_good = 32'd0;
    pred_crc_fail = 32'd0;
    pred_resync = 32'd0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    byte_in <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] body_byte(input fill_t fill, input int k);
    logic [7:0] v;
    case (fill)
      FILL_LOW:  v = 8'h00;
      FILL_HIGH: v = 8'hFF;
      FILL_EDGE: begin
        case (k % 6)
          0:       v = 8'h80;
          1:       v = 8'h00;
          2:       v = 8'h80;
          3:       v = 8'hFF;
          4:       v = 8'h7F;
          default: v = 8'h01;
        endcase
      end
      default: begin
        if ($urandom_range(0, 5) == 0) v = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        else v = 8'($urandom);
      end
    endcase
    return v;
  endfunction

  task automatic send_frame(input logic ctl, input defect_t defect, input fill_t fill,
                            input bit skip_first);
    logic [7:0]  fb [$];
    logic [7:0]  v;
    logic [15:0] crc;
    logic [15:0] trailer;
    int          body_len;
    int          stop;
    body_len = ctl ? CONTROL_FRAME_BYTES - 5 : VELOCITY_FRAME_BYTES - 5;
    fb.push_back(cur_sync_first);
    fb.push_back(cur_sync_second);
    if (defect == DEF_VERSION || (defect == DEF_VERSION_SYNC &&
        (cur_sync_first == cur_vel_ver || cur_sync_first == cur_ctl_ver))) begin
      v = cur_vel_ver;
      while (v == cur_vel_ver || v == cur_ctl_ver) v = 8'($urandom);
    end else if (defect == DEF_VERSION_SYNC) begin
      v = cur_sync_first;
    end else begin
      v = ctl ? cur_ctl_ver : cur_vel_ver;
    end
    fb.push_back(v);
    for (int k = 0; k < body_len; k++) fb.push_back(body_byte(fill, k));
    if (ctl) begin
      if (defect == DEF_COUNT) begin
        v = 8'($urandom_range(PAYLOAD_MAX_BYTES + 1, 15));
        fb[CTL_COUNT_POS] = ($urandom_range(0, 3) == 0) ? 8'hFF : v;
      end else begin
        case (fill)
          FILL_LOW:    fb[CTL_COUNT_POS] = 8'd0;
          FILL_RANDOM: fb[CTL_COUNT_POS] = 8'($urandom_range(0, PAYLOAD_MAX_BYTES));
          default:     fb[CTL_COUNT_POS] = 8'(PAYLOAD_MAX_BYTES);
        endcase
      end
    end
    crc = CRC_INIT;
    foreach (fb[i]) crc = ccitt_update(crc, fb[i]);
    trailer = crc;
    if (defect == DEF_CRC) begin
      trailer = crc ^ (16'h0001 << $urandom_range(0, 15));
    end else if (defect == DEF_CRC_TAIL) begin
      v = 8'($urandom);
      trailer = {cur_sync_first, v};
      if (trailer == crc) trailer[0] = ~trailer[0];
    end
    fb.push_back(trailer[7:0]);
    fb.push_back(trailer[15:8]);
    if (defect == DEF_SECOND) begin
      v = cur_sync_second;
      while (v == cur_sync_second || v == cur_sync_first) v = 8'($urandom);
      fb[1] = v;
    end else if (defect == DEF_REPEAT) begin
      repeat ($urandom_range(1, 3)) fb.push_front(cur_sync_first);
    end
    stop = fb.size();
    if (defect == DEF_TRUNCATE) stop = $urandom_range(3, fb.size() - 2);
    for (int i = skip_first ? 1 : 0; i < stop; i++) send_byte(fb[i]);
    frames_sent++;
  endtask

  // When the parser already holds a first sync byte, the next frame may
  // start right after it.
  task automatic send_random_frame(input int damage_pct);
    logic    ctl;
    defect_t d;
    bit      skip;
    ctl = 1'($urandom_range(0, 1));
    d = DEF_NONE;
    if ($urandom_range(1, 100) <= damage_pct) begin
      d = defect_t'($urandom_range(int'(DEF_CRC), int'(DEF_TRUNCATE)));
    end
    if (d == DEF_COUNT && !ctl) d = DEF_CRC;
    skip = (bytes_in_frame == 5'd1) && ($urandom_range(0, 1) == 1);
    send_frame(ctl, d, FILL_RANDOM, skip);
  endtask

  task automatic send_noise(input int count);
    logic [7:0] v;
    for (int i = 0; i < count; i++) begin
      v = 8'($urandom);
      send_byte(($urandom_range(0, 3) == 0) ? cur_sync_first : v);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic close_open_frame();
    logic [7:0] v;
    while (bytes_in_frame != 5'd0) begin
      v = cur_sync_first;
      while (v == cur_sync_first || v == cur_sync_second) v = 8'($urandom);
      send_byte(v);
    end
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SYNC_FIRST:       cur_sync_first = value;
      CFG_SYNC_SECOND:      cur_sync_second = value;
      CFG_VELOCITY_VERSION: cur_vel_ver = value;
      default:              cur_ctl_ver = value;
    endcase
    @(negedge clk);
  endtask

  task automatic exercise_setting(input logic [7:0] sf, ss, vv, cv, input int frames);
    close_open_frame();
    drain_results();
    write_register(CFG_SYNC_FIRST, sf);
    write_register(CFG_SYNC_SECOND, ss);
    write_register(CFG_VELOCITY_VERSION, vv);
    write_register(CFG_CONTROL_VERSION, cv);
    settings_used++;
    send_noise($urandom_range(2, 6));
    repeat (frames) send_random_frame(30);
  endtask

  task automatic test_directed_frames();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_SECOND_RESET);
    send_frame(1'b0, DEF_NONE, FILL_EDGE, 1'b0);
    send_frame(1'b1, DEF_NONE, FILL_HIGH, 1'b0);
    send_frame(1'b1, DEF_NONE, FILL_LOW, 1'b0);
    send_frame(1'b0, DEF_NONE, FILL_LOW, 1'b0);
    send_frame(1'b0, DEF_NONE, FILL_HIGH, 1'b0);
    send_frame(1'b1, DEF_NONE, FILL_EDGE, 1'b0);
    send_frame(1'b0, DEF_CRC, FILL_RANDOM, 1'b0);
    send_frame(1'b1, DEF_CRC_TAIL, FILL_RANDOM, 1'b0);
    send_frame(1'b0, DEF_NONE, FILL_RANDOM, 1'b1);
    send_frame(1'b1, DEF_COUNT, FILL_RANDOM, 1'b0);
    send_frame(1'b1, DEF_COUNT, FILL_HIGH, 1'b0);
    send_frame(1'b0, DEF_VERSION, FILL_RANDOM, 1'b0);
    send_frame(1'b1, DEF_VERSION_SYNC, FILL_RANDOM, 1'b0);
    send_frame(1'b1, DEF_NONE, FILL_RANDOM, 1'b1);
    send_frame(1'b0, DEF_SECOND, FILL_RANDOM, 1'b0);
    send_frame(1'b1, DEF_REPEAT, FILL_RANDOM, 1'b0);
    send_frame(1'b0, DEF_TRUNCATE, FILL_RANDOM, 1'b0);
    send_frame(1'b1, DEF_NONE, FILL_RANDOM, 1'b0);
  endtask

  task automatic test_register_settings();
    exercise_setting(8'h00, 8'hFF, 8'hFF, 8'h00, 5);
    exercise_setting(8'hFF, 8'h00, 8'h00, 8'hFF, 5);
    exercise_setting(8'h3C, 8'h3C, 8'h10, 8'h20, 5);
    exercise_setting(SYNC_FIRST_RESET, SYNC_SECOND_RESET, 8'h07, 8'h07, 5);
    exercise_setting(8'hC3, 8'h5A, 8'h80, 8'h7F, 5);
    exercise_setting(SYNC_FIRST_RESET, SYNC_SECOND_RESET, VELOCITY_VERSION_RESET,
                     CONTROL_VERSION_RESET, 5);
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_request = 1'b1;
    repeat (3) send_random_frame(0);
    drain_results();
    idle_on = 1'b1;
  endtask

  task automatic test_random_stream();
    int target;
    target = bytes_sent + 440;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 8));
      else send_random_frame(35);
      if ($urandom_range(0, 39) == 0) drain_results();
    end
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    repeat (12) send_random_frame(30);
  endtask

  initial begin
    reset_block();
    test_directed_frames();
    test_register_settings();
    test_backpressure();
    test_random_stream();
    test_no_idle();
    drain_results();
    repeat (10) @(negedge clk);
    errors += pending_results.size();
    $display("Run covered %0d bytes in %0d frames under %0d register settings.",
             bytes_sent, frames_sent, settings_used);
    $display("Checked %0d result words with %0d mismatches.", words_checked, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/scfp_pkg.sv
src/scfp_front.sv
src/scfp_queue.sv
src/scfp_back.sv
src/sync_crc_frame_parser_unit.sv
sim/tb_sync_crc_frame_parser_unit.sv
